>>> rtl/core/lzwc_pkg.sv
// Shared types and constants of the LZW compressor.
package lzwc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 12;
  localparam int unsigned NEXT_W = 13;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Codes below this value stand for the single bytes.
  localparam logic [NEXT_W-1:0] ALPHABET = 13'd256;
  localparam logic [CODE_W-1:0] CODE_LIMIT_RESET = 12'd4095;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_CODE_LIMIT = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } lzwc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_code;
    logic              out_last;
  } lzwc_out_t;

  // One slot of the hashed dictionary.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] sym;
    logic [CODE_W-1:0] code;
  } lzwc_entry_t;

endpackage

>>> rtl/core/lzw_compressor_core.sv
// Top level of the LZW compressor: sequencer, hashed dictionary memory and register port.
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  ------------------------------
//  input     in         in_valid_i / in_stall_o       in_data_i  (in_byte, end_of_stream)
//  output    out        out_valid_o / out_stall_i     out_data_o (out_code, out_last)
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata (code_limit)
//
// A byte that starts a stream is taken in ST_IDLE; others pass ST_READ and ST_CHECK,
// return to ST_IDLE when the pair is found and go on to ST_EMIT when they end the prefix.
// Every further probe of the dictionary memory, which has a single read port, repeats
// ST_READ and ST_CHECK. A request with end_of_stream adds ST_EMIT for the final code
// and then a clearing pass over all DICT_SIZE slots, also run after reset before any byte.
// A stalled output only holds the block when a further code has to be loaded.
module lzw_compressor_core #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lzwc_pkg::lzwc_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lzwc_pkg::lzwc_out_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lzwc_pkg::APB_AW-1:0]         paddr,
  input  logic [lzwc_pkg::APB_DW-1:0]         pwdata,
  output logic [lzwc_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import lzwc_pkg::*;

  localparam int unsigned AW = $clog2(DICT_SIZE);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DICT_SIZE - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [CODE_W-1:0] prefix_q, prefix_d;
  logic              prefix_valid_q, prefix_valid_d;
  logic [NEXT_W-1:0] next_code_q, next_code_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              eos_q, eos_d;
  logic [CODE_W-1:0] em_code_q, em_code_d;
  logic              em_last_q, em_last_d;
  logic              out_valid_q, out_valid_d;
  lzwc_out_t         out_data_q, out_data_d;
  logic [CODE_W-1:0] code_limit_q;

  lzwc_entry_t       dict_mem [DICT_SIZE];
  lzwc_entry_t       rd_q;
  logic              wr_en;
  lzwc_entry_t       wr_data;

  logic              out_free;
  logic              pair_hit;
  logic              room;
  logic [AW-1:0]     slot_inc;

  // Spreads the (prefix, byte) key over the slots; any collision is resolved by probing
  // the following slots, and the table always keeps free slots, so a probe run ends.
  function automatic logic [AW-1:0] hash_slot(input logic [CODE_W-1:0] p,
                                               input logic [BYTE_W-1:0] b);
    logic [19:0]   key;
    logic [19:0]   mix;
    logic [AW-1:0] h;
    key = {b, p};
    mix = key ^ {key[10:0], key[19:11]};
    h   = AW'(mix);
    if (32'(h) >= DICT_SIZE) begin
      h = h - AW'(DICT_SIZE);
    end
    return h;
  endfunction

  // The register port is always ready; a write lands in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CODE_LIMIT) ? APB_DW'(code_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_limit_q <= CODE_LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CODE_LIMIT)) begin
      code_limit_q <= pwdata[CODE_W-1:0];
    end
  end

  // The dictionary memory: one write port and one registered read port, both at the
  // current slot. The read runs every cycle, so the data is there in the cycle after
  // the slot settles.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dict_mem[slot_q] <= wr_data;
    end
    rd_q <= dict_mem[slot_q];
  end

  assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pair_hit = rd_q.valid && (rd_q.prefix == prefix_q) && (rd_q.sym == byte_q);
  // A new pair is added only while the next code is within both the programmed limit
  // and the size of the table.
  assign room     = (next_code_q <= {1'b0, code_limit_q}) && (32'(next_code_q) < DICT_SIZE);

  always_comb begin
    state_d        = state_q;
    slot_d         = slot_q;
    prefix_d       = prefix_q;
    prefix_valid_d = prefix_valid_q;
    next_code_d    = next_code_q;
    byte_d         = byte_q;
    eos_d          = eos_q;
    em_code_d      = em_code_q;
    em_last_d      = em_last_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    wr_en          = 1'b0;
    wr_data        = '0;

    // The output register empties when its code is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the memory one slot a cycle, clearing every valid mark.
        wr_en = 1'b1;
        if (slot_q == LAST_SLOT) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end else begin
          slot_d = slot_inc;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_data_i.in_byte;
          eos_d  = in_data_i.end_of_stream;
          if (!prefix_valid_q) begin
            // First byte of a stream becomes the prefix, emitted too if it ends the stream.
            prefix_d       = CODE_W'(in_data_i.in_byte);
            prefix_valid_d = 1'b1;
            if (in_data_i.end_of_stream) begin
              em_code_d = CODE_W'(in_data_i.in_byte);
              em_last_d = 1'b1;
              state_d   = ST_EMIT;
            end
          end else begin
            slot_d  = hash_slot(prefix_q, in_data_i.in_byte);
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (pair_hit) begin
          prefix_d = rd_q.code;
          if (eos_q) begin
            em_code_d = rd_q.code;
            em_last_d = 1'b1;
            state_d   = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!rd_q.valid) begin
          // Pair absent: this free slot takes it if there is room; the prefix is emitted.
          if (room) begin
            wr_en          = 1'b1;
            wr_data.valid  = 1'b1;
            wr_data.prefix = prefix_q;
            wr_data.sym    = byte_q;
            wr_data.code   = next_code_q[CODE_W-1:0];
            next_code_d    = next_code_q + 1'b1;
          end
          em_code_d = prefix_q;
          em_last_d = 1'b0;
          prefix_d  = CODE_W'(byte_q);
          state_d   = ST_EMIT;
        end else begin
          slot_d  = slot_inc;
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.out_code = em_code_q;
          out_data_d.out_last = em_last_q;
          if (em_last_q) begin
            // End of stream: start a fresh dictionary.
            prefix_d       = '0;
            prefix_valid_d = 1'b0;
            next_code_d    = ALPHABET;
            slot_d         = '0;
            state_d        = ST_CLEAR;
          end else if (eos_q) begin
            em_code_d = prefix_q;
            em_last_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        slot_d  = '0;
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      slot_q         <= '0;
      prefix_q       <= '0;
      prefix_valid_q <= 1'b0;
      next_code_q    <= ALPHABET;
      eos_q          <= 1'b0;
      em_last_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      slot_q         <= slot_d;
      prefix_q       <= prefix_d;
      prefix_valid_q <= prefix_valid_d;
      next_code_q    <= next_code_d;
      eos_q          <= eos_d;
      em_last_q      <= em_last_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    em_code_q  <= em_code_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/lzwc_checker.sv
// Port-level checks of the LZW compressor and their binding to the top level.
module lzwc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input lzwc_pkg::lzwc_in_t          in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input lzwc_pkg::lzwc_out_t         out_data_o
);
  import lzwc_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or was withdrawn");

  // The dictionary is swept after reset, so no request is taken straight away.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o)
    else $error("request accepted during the clearing pass after reset");

  // Nothing is offered in the cycle after reset has been seen.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered straight after reset");

  // A request that ends the stream always leaves a final code to deliver.
  a_eos_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_stream |=> in_stall_o)
    else $error("block ready again straight after an end-of-stream request");

endmodule

bind lzw_compressor_core lzwc_checker u_lzwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> sim/lzwc_tracker_pkg.sv
// Scoreboard class that predicts the LZW code stream and checks every emitted code.
`timescale 1ns / 100ps
package lzwc_tracker_pkg;
  import lzwc_pkg::*;

  class lzw_code_tracker #(int unsigned DICT_SIZE = 4096);
    typedef bit [CODE_W+BYTE_W-1:0] pair_t;

    // Dictionary of the current stream, keyed by the pair {prefix code, byte}.
    bit [CODE_W-1:0] pair_code[pair_t];
    logic [CODE_W-1:0] prefix;
    bit                have_prefix;
    logic [NEXT_W-1:0] next_code;
    logic [CODE_W-1:0] code_limit;
    lzwc_out_t         codes_due[$];
    int unsigned       failures;

    function new();
      code_limit = CODE_LIMIT_RESET;
      failures = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      pair_code.delete();
      next_code = ALPHABET;
      prefix = '0;
      have_prefix = 1'b0;
    endfunction

    function void set_limit(logic [CODE_W-1:0] value);
      code_limit = value;
    endfunction

    function int unsigned outstanding();
      return codes_due.size();
    endfunction

    // Works out the codes that one accepted byte releases.
    function void note_byte(lzwc_in_t req);
      pair_t     key;
      lzwc_out_t code;
      if (!have_prefix) begin
        prefix = CODE_W'(req.in_byte);
        have_prefix = 1'b1;
      end else begin
        key = {prefix, req.in_byte};
        if (pair_code.exists(key)) begin
          prefix = pair_code[key];
        end else begin
          if (next_code <= code_limit && next_code < DICT_SIZE) begin
            pair_code[key] = next_code[CODE_W-1:0];
            next_code = next_code + 1'b1;
          end
          code.out_code = prefix;
          code.out_last = 1'b0;
          codes_due.push_back(code);
          prefix = CODE_W'(req.in_byte);
        end
      end
      if (req.end_of_stream) begin
        code.out_code = prefix;
        code.out_last = 1'b1;
        codes_due.push_back(code);
        restart_stream();
      end
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void check_code(lzwc_out_t got);
      lzwc_out_t want;
      if (codes_due.size() == 0) begin
        flag($sformatf("code %0d last %0b arrived with nothing due",
                       got.out_code, got.out_last));
        return;
      end
      want = codes_due.pop_front();
      if (got.out_code !== want.out_code || got.out_last !== want.out_last) begin
        flag($sformatf("expected code %0d last %0b, got code %0d last %0b",
                       want.out_code, want.out_last, got.out_code, got.out_last));
      end
    endfunction
  endclass

endpackage

>>> sim/lzw_compressor_core_test.sv
// Top of the LZW compressor test: clock, reset, request drivers, monitor and watchdog.
`timescale 1ns / 100ps
module lzw_compressor_core_test;
  import lzwc_pkg::*;
  import lzwc_tracker_pkg::*;

  localparam int unsigned DICT_SIZE = 4096;
  // The longest honest silence is the clearing pass after reset or after an end of
  // stream, plus the pause before a register write; allow several times that.
  localparam int unsigned QUIET_LIMIT = 8 * DICT_SIZE;
  localparam int unsigned BYTES_PER_PHASE = 125;

  // The opening requests, each written as {byte, end_of_stream}. They cover a lone
  // byte at both ends of the byte range, an alternating pattern that keeps hitting
  // the dictionary, a byte that both ends a prefix and ends the stream, a run of one
  // value, and alternating bit patterns.
  localparam logic [BYTE_W:0] OPENING [20] = '{
    {8'h00, 1'b1},
    {8'hFF, 1'b1},
    {8'h41, 1'b0}, {8'h42, 1'b0}, {8'h41, 1'b0}, {8'h42, 1'b0},
    {8'h41, 1'b0}, {8'h42, 1'b0}, {8'h41, 1'b1},
    {8'h01, 1'b0}, {8'h02, 1'b1},
    {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
    {8'h55, 1'b0}, {8'hAA, 1'b0}, {8'h55, 1'b0}, {8'hAA, 1'b1}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  lzwc_in_t             in_data = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  lzwc_out_t            out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  lzw_code_tracker #(DICT_SIZE) tracker;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  lzw_compressor_core #(
    .DICT_SIZE(DICT_SIZE)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The receiver decides afresh on every cycle whether to hold the output back, so
  // stalls land on every phase of the block's work, not only while a code waits.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor and watchdog. Both handshakes are sampled at the rising edge, before the
  // block's own registers move. The input request is noted first, so that the
  // predictor is always ahead of anything the block can return.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        tracker.note_byte(in_data);
      end
      if (out_valid_o && !out_stall) begin
        tracker.check_code(out_data_o);
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL lzw_compressor_core");
        $finish;
      end
    end
  end

  // One input request. The sender may first sit idle, as send_idle_pct draws; valid
  // is set exactly once per falling edge, so a request that follows straight on
  // keeps valid high without a glitch.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= {value, last};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Register write: a setup phase, then an access phase that completes at the rising
  // edge with pready high. The predictor takes the new limit at that same edge.
  task automatic write_reg(input logic [CODE_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CODE_LIMIT, 2'b00};
    pwdata <= {{(APB_DW-CODE_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_limit(value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One stream of random content. Most streams draw on a handful of byte values, so
  // the dictionary keeps matching and prefixes grow long, and close with an end of
  // stream. Some run on into the next stream without one, and some are plain noise.
  task automatic run_stream();
    logic [BYTE_W-1:0] syms [4];
    logic [BYTE_W-1:0] value;
    int unsigned       kind;
    int unsigned       len;
    int unsigned       spread;
    int unsigned       n;
    logic              closes;
    kind = $urandom_range(9);
    len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
    spread = $urandom_range(1, 4);
    closes = (kind < 6) || (kind >= 8 && $urandom_range(1) == 1);
    foreach (syms[k]) syms[k] = BYTE_W'($urandom_range(255));
    for (n = 1; n <= len; n++) begin
      value = (kind >= 8) ? BYTE_W'($urandom_range(255))
                          : syms[2'($urandom_range(spread - 1))];
      send_byte(value, closes && n == len);
    end
  endtask

  // A phase starts only once every due code has come out and the block has had time
  // for a clearing pass and for a byte that released nothing, so the register write
  // always meets an idle block.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input logic [CODE_W-1:0] limit, input bit opening);
    int unsigned goal;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DICT_SIZE + 64) @(posedge clk_i);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    write_reg(limit);
    if (opening) begin
      foreach (OPENING[i]) send_byte(OPENING[i][BYTE_W:1], OPENING[i][0]);
    end
    goal = bytes_sent + BYTES_PER_PHASE;
    while (bytes_sent < goal) run_stream();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Limits run from the reset value down to one that lets a single entry in, then
    // to zero, where nothing is ever added, and finally a random moderate value.
    run_phase(0, 0, CODE_LIMIT_RESET, 1'b1);
    run_phase(66, 0, ALPHABET[CODE_W-1:0], 1'b0);
    run_phase(0, 66, '0, 1'b0);
    run_phase(21, 21, CODE_W'($urandom_range(257, 600)), 1'b0);

    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("PASS lzw_compressor_core");
    end else begin
      $display("FAIL lzw_compressor_core");
    end
    $finish;
  end

endmodule
